/* rtl/button_debounce_short_long_press_macros.svh */
// ----------------------------------------------------------------------------
// button debounce assertion macros
// shared concurrent assertion forms, clocked on clk, held off during reset
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_SHORT_LONG_PRESS_MACROS_SVH
`define BUTTON_DEBOUNCE_SHORT_LONG_PRESS_MACROS_SVH

// same-cycle implication
`define BDSLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define BDSLP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/bdslp_pkg.sv */
// ----------------------------------------------------------------------------
// bdslp_pkg
// types and constants of the button debouncer with short and long press
// ----------------------------------------------------------------------------
package bdslp_pkg;

  localparam int BUTTON_COUNT = 4;
  localparam int STAMP_W      = 32;
  localparam int TIME_W       = 16;
  localparam int CODE_W       = 3;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  localparam logic [TIME_W-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [TIME_W-1:0] LONG_PRESS_RESET = 16'd1500;

  // register index, taken from paddr word bit
  localparam logic REG_DEBOUNCE   = 1'b0;
  localparam logic REG_LONG_PRESS = 1'b1;

  typedef enum logic [CODE_W-1:0] {
    EV_NONE            = 3'd0,
    EV_UP              = 3'd1,
    EV_DOWN            = 3'd2,
    EV_SELECT          = 3'd3,
    EV_START_STOP      = 3'd4,
    EV_SELECT_LONG     = 3'd5,
    EV_START_STOP_LONG = 3'd6
  } event_t;

  // link handed from one button cell to the next
  typedef struct packed {
    logic   taken;
    event_t code;
  } link_t;

  function automatic event_t short_code(input int idx);
    case (idx)
      0:       short_code = EV_UP;
      1:       short_code = EV_DOWN;
      2:       short_code = EV_SELECT;
      3:       short_code = EV_START_STOP;
      default: short_code = EV_NONE;
    endcase
  endfunction

  function automatic event_t long_code(input int idx);
    case (idx)
      2:       long_code = EV_SELECT_LONG;
      3:       long_code = EV_START_STOP_LONG;
      default: long_code = EV_NONE;
    endcase
  endfunction

endpackage

/* rtl/bdslp_if.sv */
// ----------------------------------------------------------------------------
// bdslp channel interfaces
// valid/ready channels for polls and for press events
// ----------------------------------------------------------------------------
interface bdslp_in_if import bdslp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STAMP_W-1:0]    now_ms;
  logic [BUTTON_COUNT-1:0] pin_levels;

  modport source (output valid, now_ms, pin_levels, input ready);
  modport sink   (input valid, now_ms, pin_levels, output ready);
endinterface

interface bdslp_out_if import bdslp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] event_code;

  modport source (output valid, event_code, input ready);
  modport sink   (input valid, event_code, output ready);
endinterface

/* rtl/bdslp_cell.sv */
// ----------------------------------------------------------------------------
// bdslp_cell
// one button: debounce stamps, press stamp and event decision
// ----------------------------------------------------------------------------
module bdslp_cell import bdslp_pkg::*; #(
  parameter event_t SHORT_CODE = EV_UP,
  parameter event_t LONG_CODE  = EV_NONE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [STAMP_W-1:0] now_ms,
  input  logic               level,
  input  logic [TIME_W-1:0]  debounce_time,
  input  logic [TIME_W-1:0]  long_press_time,
  input  link_t              link_in,
  output link_t              link_out
);

  logic               prev_r, prev_nxt;
  logic               sr_r, sr_nxt;
  logic               ld_r, ld_nxt;
  logic [STAMP_W-1:0] cs_r, cs_nxt;
  logic [STAMP_W-1:0] ps_r, ps_nxt;

  logic               pressed, settled, start, ld_eff, long_hit, short_hit, fire;
  logic [STAMP_W-1:0] cs_eff, ps_eff, since_change, held;
  event_t             my_code;

  always_comb begin
    pressed      = ~level;
    cs_eff       = (level != prev_r) ? now_ms : cs_r;
    since_change = now_ms - cs_eff;
    settled      = since_change >= {{(STAMP_W-TIME_W){1'b0}}, debounce_time};
    start        = pressed & sr_r;
    ps_eff       = start ? now_ms : ps_r;
    ld_eff       = start ? 1'b0 : ld_r;
    held         = now_ms - ps_eff;
    long_hit     = pressed & ~ld_eff &
                   (held >= {{(STAMP_W-TIME_W){1'b0}}, long_press_time});
    short_hit    = ~pressed & ~sr_r & ~ld_eff;
    // up and down record the long hold but stay silent
    fire         = settled & ((long_hit & (LONG_CODE != EV_NONE)) | short_hit);
    my_code      = long_hit ? LONG_CODE : SHORT_CODE;
  end

  always_comb begin
    prev_nxt = prev_r;
    cs_nxt   = cs_r;
    ps_nxt   = ps_r;
    ld_nxt   = ld_r;
    sr_nxt   = sr_r;
    if (en && !link_in.taken) begin
      prev_nxt = level;
      cs_nxt   = cs_eff;
      if (settled) begin
        ps_nxt = ps_eff;
        ld_nxt = ld_eff | long_hit;
        sr_nxt = ~pressed;
      end
    end
  end

  always_comb begin
    link_out.taken = link_in.taken | fire;
    link_out.code  = link_in.taken ? link_in.code : (fire ? my_code : EV_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b1;
      sr_r   <= 1'b1;
      ld_r   <= 1'b0;
      cs_r   <= '0;
      ps_r   <= '0;
    end else begin
      prev_r <= prev_nxt;
      sr_r   <= sr_nxt;
      ld_r   <= ld_nxt;
      cs_r   <= cs_nxt;
      ps_r   <= ps_nxt;
    end
  end

endmodule

/* rtl/button_debounce_short_long_press.sv */
// ----------------------------------------------------------------------------
// button_debounce_short_long_press
// four-button debouncer giving short and long press events per poll
// ----------------------------------------------------------------------------
//  channel   dir   transfer carries                 handshake
//  in_ch     in    now_ms[31:0], pin_levels[3:0]    valid/ready
//  out_ch    out   event_code[2:0], one per poll    valid/ready
//  apb       in    debounce_time @0, long_press @4  psel/penable, pready = 1
//
//  one poll per cycle: the four button cells form a chain evaluated in a
//  single cycle, each passing an event-taken flag to the next
//  results sit in a two-entry output queue, so a poll is taken even while
//  one result waits; in_ch.ready drops only when both entries are full
//  a result is queued at its poll transfer, behind any result still waiting
//  synchronous active-low reset puts every button in the released state
// ----------------------------------------------------------------------------
`include "button_debounce_short_long_press_macros.svh"

module button_debounce_short_long_press import bdslp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bdslp_in_if.sink              in_ch,
  bdslp_out_if.source           out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  // configuration registers
  logic [TIME_W-1:0] debounce_r, debounce_nxt;
  logic [TIME_W-1:0] long_press_r, long_press_nxt;
  logic              cfg_wr;

  // output queue
  event_t     q_r [2];
  event_t     q_nxt [2];
  logic [1:0] count_r, count_nxt;

  logic   in_acc, out_pop;
  link_t  link [BUTTON_COUNT+1];
  event_t poll_code;

  // apb access, register chosen by the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    debounce_nxt   = debounce_r;
    long_press_nxt = long_press_r;
    if (cfg_wr) begin
      case (paddr[2])
        REG_DEBOUNCE:   debounce_nxt   = pwdata[TIME_W-1:0];
        REG_LONG_PRESS: long_press_nxt = pwdata[TIME_W-1:0];
        default:        debounce_nxt   = debounce_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DEBOUNCE:   prdata = {{(APB_DATA_W-TIME_W){1'b0}}, debounce_r};
      REG_LONG_PRESS: prdata = {{(APB_DATA_W-TIME_W){1'b0}}, long_press_r};
      default:        prdata = '0;
    endcase
  end

  // handshakes
  assign in_acc            = in_ch.valid & in_ch.ready;
  assign out_pop           = out_ch.valid & out_ch.ready;
  assign in_ch.ready       = (count_r != 2'd2);
  assign out_ch.valid      = (count_r != 2'd0);
  assign out_ch.event_code = q_r[0];

  // button cell chain, button 0 has first claim on the poll
  assign link[0] = '{taken: 1'b0, code: EV_NONE};

  for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_cell
    bdslp_cell #(
      .SHORT_CODE (short_code(i)),
      .LONG_CODE  (long_code(i))
    ) u_cell (
      .clk             (clk),
      .rst_n           (rst_n),
      .en              (in_acc),
      .now_ms          (in_ch.now_ms),
      .level           (in_ch.pin_levels[i]),
      .debounce_time   (debounce_r),
      .long_press_time (long_press_r),
      .link_in         (link[i]),
      .link_out        (link[i+1])
    );
  end

  assign poll_code = link[BUTTON_COUNT].code;

  // two-entry queue, head is q_r[0]
  always_comb begin
    q_nxt[0]  = q_r[0];
    q_nxt[1]  = q_r[1];
    count_nxt = count_r;
    case ({in_acc, out_pop})
      2'b11: begin
        if (count_r == 2'd1) begin
          q_nxt[0] = poll_code;
        end else begin
          q_nxt[0] = q_r[1];
          q_nxt[1] = poll_code;
        end
      end
      2'b10: begin
        if (count_r == 2'd0) begin
          q_nxt[0] = poll_code;
        end else begin
          q_nxt[1] = poll_code;
        end
        count_nxt = count_r + 2'd1;
      end
      2'b01: begin
        q_nxt[0]  = q_r[1];
        count_nxt = count_r - 2'd1;
      end
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RESET;
      long_press_r <= LONG_PRESS_RESET;
      count_r      <= 2'd0;
    end else begin
      debounce_r   <= debounce_nxt;
      long_press_r <= long_press_nxt;
      count_r      <= count_nxt;
    end
  end

  // queue payload needs no reset
  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  // checks
  `BDSLP_ASSERT_IMP(a_queue_bound, 1'b1, count_r != 2'd3)
  `BDSLP_ASSERT_NXT(a_queue_grows, in_acc && !out_pop, count_r == $past(count_r) + 2'd1)
  `BDSLP_ASSERT_IMP(a_code_range, out_ch.valid, out_ch.event_code <= EV_START_STOP_LONG)
  `BDSLP_ASSERT_NXT(a_cfg_debounce, cfg_wr && (paddr[2] == REG_DEBOUNCE), debounce_r == $past(pwdata[TIME_W-1:0]))

endmodule

/* tb/bdslp_event_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdslp_event_checker
// watches the poll, event and register ports, predicts one press event per
// poll transfer and compares each event transfer against the oldest guess
// ----------------------------------------------------------------------------
module bdslp_event_checker import bdslp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bdslp_in_if                   poll_ch,
  bdslp_out_if                  ev_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending,
  output int                    events_seen
);

  // shadow registers and per-button tracking state
  logic [TIME_W-1:0]       settle_ms;
  logic [TIME_W-1:0]       long_ms;
  logic [BUTTON_COUNT-1:0] last_level;
  logic [BUTTON_COUNT-1:0] released;
  logic [BUTTON_COUNT-1:0] long_fired;
  logic [STAMP_W-1:0]      chg_stamp  [BUTTON_COUNT];
  logic [STAMP_W-1:0]      hold_start [BUTTON_COUNT];

  event_t expected_events [$];
  int     errs;
  int     ev_total;

  initial begin
    errs     = 0;
    ev_total = 0;
  end

  // advances the button state by one poll and gives the press event it causes
  function automatic event_t next_event(input logic [STAMP_W-1:0] now,
                                        input logic [BUTTON_COUNT-1:0] pins);
    logic               pressed;
    logic [STAMP_W-1:0] since;
    logic [STAMP_W-1:0] held;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      pressed = ~pins[b];
      if (pins[b] != last_level[b])
        chg_stamp[b] = now;
      last_level[b] = pins[b];

      since = now - chg_stamp[b];
      if (since < {16'd0, settle_ms})
        continue;

      if (pressed && released[b]) begin
        hold_start[b] = now;
        long_fired[b] = 1'b0;
      end

      held = now - hold_start[b];
      if (pressed && !long_fired[b] && held >= {16'd0, long_ms}) begin
        long_fired[b] = 1'b1;
        released[b]   = 1'b0;
        if (b == 3) return EV_START_STOP_LONG;
        if (b == 2) return EV_SELECT_LONG;
      end

      if (!pressed && !released[b] && !long_fired[b]) begin
        released[b] = 1'b1;
        case (b)
          0:       return EV_UP;
          1:       return EV_DOWN;
          2:       return EV_SELECT;
          default: return EV_START_STOP;
        endcase
      end

      released[b] = ~pressed;
    end
    return EV_NONE;
  endfunction

  always @(posedge clk) begin
    event_t want;
    if (!rst_n) begin
      settle_ms   = DEBOUNCE_RESET;
      long_ms     = LONG_PRESS_RESET;
      last_level  = '1;
      released    = '1;
      long_fired  = '0;
      for (int b = 0; b < BUTTON_COUNT; b++) begin
        chg_stamp[b]  = '0;
        hold_start[b] = '0;
      end
      expected_events.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_DEBOUNCE)
          settle_ms = pwdata[TIME_W-1:0];
        else
          long_ms = pwdata[TIME_W-1:0];
      end

      if (poll_ch.valid && poll_ch.ready)
        expected_events.push_back(next_event(poll_ch.now_ms, poll_ch.pin_levels));

      if (ev_ch.valid && ev_ch.ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: event transfer with no poll waiting, expected none, got %0d",
                   $time, ev_ch.event_code);
          errs++;
        end else begin
          want = expected_events.pop_front();
          if (ev_ch.event_code !== want) begin
            $display("%0t: event code mismatch, expected %0d, got %0d",
                     $time, want, ev_ch.event_code);
            errs++;
          end
          if (want != EV_NONE)
            ev_total++;
        end
      end
    end
    fail_count  <= errs;
    pending     <= expected_events.size();
    events_seen <= ev_total;
  end

endmodule

/* tb/tb_button_debounce_short_long_press.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_short_long_press
// drives button polls and register writes into the debouncer, stalls the
// event side at random and leaves all checking to bdslp_event_checker
// ----------------------------------------------------------------------------
module tb_button_debounce_short_long_press;
  import bdslp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
  localparam int LONG_STALL     = 64;    // long event-side hold-off

  logic clk;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bdslp_in_if  poll_ch ();
  bdslp_out_if ev_ch ();

  int fail_count;
  int pending;
  int events_seen;

  // stimulus bookkeeping
  logic [STAMP_W-1:0]      t_ms;     // running millisecond clock
  logic [BUTTON_COUNT-1:0] lv;       // current pin levels
  int unsigned             deb_now;
  int unsigned             lpt_now;
  int                      polls_sent;
  int                      settings_used;
  int                      stuck_cycles;
  bit                      quiet_tail;   // no idling on either side
  bit                      stall_req;    // ask the event side for a long hold-off
  bit                      rx_stalling;

  button_debounce_short_long_press dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (poll_ch),
    .out_ch  (ev_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bdslp_event_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .poll_ch     (poll_ch),
    .ev_ch       (ev_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .events_seen (events_seen)
  );

  // 20 ns clock, first rising edge at 10 ns
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // watchdog: any poll, event or register transfer counts as progress
  always @(posedge clk) begin
    if (!rst_n || (poll_ch.valid && poll_ch.ready) || (ev_ch.valid && ev_ch.ready) ||
        psel)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // event side: random ready bursts, one long hold-off on request
  initial begin
    ev_ch.ready <= 1'b0;
    forever begin
      if (stall_req) begin
        // hold off long enough for the result queue to fill and block polls
        rx_stalling = 1'b1;
        ev_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_req   = 1'b0;
        rx_stalling = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        ev_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        ev_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // offers one poll and waits for its transfer; valid stays high afterwards
  task automatic send_poll(input logic [STAMP_W-1:0] t, input logic [BUTTON_COUNT-1:0] p);
    int gap;
    if (!quiet_tail && !rx_stalling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      poll_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    poll_ch.valid      <= 1'b1;
    poll_ch.now_ms     <= t;
    poll_ch.pin_levels <= p;
    do @(posedge clk); while (!poll_ch.ready);
    polls_sent++;
  endtask

  // drops valid and waits until every poll has its event back
  task automatic drain();
    poll_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // a little slack, since the checker's pending count is registered
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [TIME_W-1:0] val);
    // setup phase, upper data bits are don't-care for a 16-bit register
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk);
    // access phase, pready is tied high
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // bus idle before the next access
    @(posedge clk);
  endtask

  task automatic apply_settings(input int unsigned deb, input int unsigned lpt);
    drain();
    apb_write(REG_DEBOUNCE, deb[TIME_W-1:0]);
    apb_write(REG_LONG_PRESS, lpt[TIME_W-1:0]);
    deb_now = deb;
    lpt_now = lpt;
    settings_used++;
  endtask

  // one press-and-release of a button set, with contact bounce on both
  // edges; now and then a few polls of plain noise instead
  task automatic gesture();
    logic [BUTTON_COUNT-1:0] mask;
    int unsigned             hold_ms;
    int unsigned             k;
    int                      n;
    if ($urandom_range(0, 6) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        lv = 4'($urandom);
        if ($urandom_range(0, 3) == 0)
          t_ms = $urandom;
        else
          t_ms += $urandom_range(0, deb_now + 2);
        send_poll(t_ms, lv);
      end
    end else begin
      // select and start-stop get most of the presses, they have long events
      case ($urandom_range(0, 9))
        0, 1:    mask = 4'b0100;
        2, 3:    mask = 4'b1000;
        4:       mask = 4'b0001;
        5:       mask = 4'b0010;
        6:       mask = 4'($urandom);
        default: mask = 4'b0001 << $urandom_range(0, 3);
      endcase
      if (mask == '0)
        mask = 4'b0001;

      // hold time past debounce: short, long, or right on the long threshold
      case ($urandom_range(0, 4))
        0, 1:    hold_ms = deb_now + ((lpt_now == 0) ? 0 : $urandom_range(0, lpt_now - 1));
        2, 3:    hold_ms = deb_now + lpt_now + $urandom_range(0, lpt_now / 2 + 10);
        default: hold_ms = deb_now + lpt_now;
      endcase

      // bounce going down
      repeat ($urandom_range(0, 3)) begin
        lv = ~(mask & 4'($urandom));
        t_ms += $urandom_range(0, deb_now / 4 + 1);
        send_poll(t_ms, lv);
      end

      // steady hold
      lv = ~mask;
      t_ms += $urandom_range(0, 3);
      send_poll(t_ms, lv);
      k = $urandom_range(2, 6);
      repeat (k) begin
        t_ms += hold_ms / k + $urandom_range(0, 2);
        send_poll(t_ms, lv);
      end

      // bounce coming up
      repeat ($urandom_range(0, 3)) begin
        lv = ~mask | (mask & 4'($urandom));
        t_ms += $urandom_range(0, deb_now / 4 + 1);
        send_poll(t_ms, lv);
      end

      // release and let it settle
      lv = '1;
      t_ms += $urandom_range(0, 3);
      send_poll(t_ms, lv);
      repeat ($urandom_range(1, 3)) begin
        t_ms += deb_now / 2 + $urandom_range(0, deb_now / 2 + 3);
        send_poll(t_ms, lv);
      end
    end
  endtask

  task automatic random_phase(input int count);
    int start;
    start = polls_sent;
    while (polls_sent - start < count)
      gesture();
  endtask

  localparam logic [STAMP_W-1:0] T0 = 32'hFFFF_FF80;  // wraps to zero 128 ms in

  initial begin
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    poll_ch.valid      <= 1'b0;
    poll_ch.now_ms     <= '0;
    poll_ch.pin_levels <= '1;
    t_ms          = '0;
    lv            = '1;
    deb_now       = 32'(DEBOUNCE_RESET);
    lpt_now       = 32'(LONG_PRESS_RESET);
    polls_sent    = 0;
    settings_used = 1;
    quiet_tail    = 1'b0;
    stall_req     = 1'b0;
    rx_stalling   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset timing, clock wraps through zero early on
    send_poll(T0, 4'hF);
    // all four pressed at once, debounced at time zero
    send_poll(T0 + 10, 4'h0);
    send_poll(T0 + 128, 4'h0);
    // long hold: up and down stay silent, select long ends the poll,
    // start-stop long fires on the next poll
    send_poll(T0 + 1700, 4'h0);
    send_poll(T0 + 1710, 4'h0);
    // release after long holds gives nothing
    send_poll(T0 + 1800, 4'hF);
    send_poll(T0 + 1860, 4'hF);
    // short up
    send_poll(T0 + 1900, 4'hE);
    send_poll(T0 + 1960, 4'hE);
    send_poll(T0 + 2000, 4'hF);
    send_poll(T0 + 2060, 4'hF);
    // down and start-stop together: down wins, start-stop comes a poll later
    send_poll(T0 + 2100, 4'h5);
    send_poll(T0 + 2160, 4'h5);
    send_poll(T0 + 2200, 4'hF);
    send_poll(T0 + 2260, 4'hF);
    send_poll(T0 + 2270, 4'hF);
    // short select
    send_poll(T0 + 2300, 4'hB);
    send_poll(T0 + 2360, 4'hB);
    send_poll(T0 + 2400, 4'hF);
    send_poll(T0 + 2460, 4'hF);
    // bounce that never settles, then a jump to the top of the clock
    send_poll(T0 + 2500, 4'hE);
    send_poll(T0 + 2510, 4'hF);
    send_poll(T0 + 2520, 4'hE);
    send_poll(32'hFFFF_FFFF, 4'hF);
    t_ms = 32'hFFFF_FFFF;

    random_phase(60);

    // both times zero: every press is a long press on its edge poll
    apply_settings(0, 0);
    random_phase(80);

    // both at max, with a long hold-off on the event side
    apply_settings(16'hFFFF, 16'hFFFF);
    stall_req = 1'b1;
    random_phase(80);

    apply_settings(0, 16'hFFFF);
    random_phase(80);

    apply_settings(16'hFFFF, 0);
    random_phase(80);

    // small random timing, with a full pause of the poll side midway
    apply_settings($urandom_range(1, 100), $urandom_range(1, 2000));
    random_phase(40);
    drain();
    random_phase(40);

    apply_settings(20, 300);
    random_phase(80);

    apply_settings($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
    random_phase(60);

    // closing stretch without idling on either side
    quiet_tail = 1'b1;
    apply_settings(10, 200);
    random_phase(80);

    drain();
    repeat (8) @(posedge clk);

    $display("run covered %0d polls under %0d register settings", polls_sent, settings_used);
    $display("%0d of the checked results were press events", events_seen);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
